// ===== hdl/bsm_pkg.sv =====
`timescale 1ns / 1ps

package bsm_pkg;

	localparam int OPERAND_WIDTH   = 8;
	localparam int PRODUCT_WIDTH   = 2 * OPERAND_WIDTH;
	localparam int STEPS_PER_STAGE = 2;
	localparam int NUM_STAGES      = (OPERAND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	// Booth pair codes: {multiplier lsb, extra bit}
	localparam logic [1:0] BOOTH_ADD = 2'b01;
	localparam logic [1:0] BOOTH_SUB = 2'b10;

	typedef struct packed {
		logic [OPERAND_WIDTH:0]   acc;
		logic [OPERAND_WIDTH-1:0] q;
		logic                     qx;
	} booth_state_t;

	// one Booth step: add/subtract, then arithmetic shift of acc:q:qx
	function automatic booth_state_t booth_step(input booth_state_t st,
		input logic [OPERAND_WIDTH:0] m);
		booth_state_t           nx;
		logic [OPERAND_WIDTH:0] acc;
		acc = st.acc;
		case ({st.q[0], st.qx})
			BOOTH_ADD: acc = st.acc + m;
			BOOTH_SUB: acc = st.acc - m;
			default:   acc = st.acc;
		endcase
		nx.qx  = st.q[0];
		nx.q   = {acc[0], st.q[OPERAND_WIDTH-1:1]};
		nx.acc = {acc[OPERAND_WIDTH], acc[OPERAND_WIDTH:1]};
		return nx;
	endfunction

endpackage

// ===== hdl/booth_signed_multiplier_core.sv =====
`timescale 1ns / 1ps

// Radix-2 Booth signed multiplier, 8 x 8 -> 16 bits two's complement.
// A request is taken on every cycle that start is high; busy is always low,
// as the pipeline never stalls. The product appears on product with done high
// for exactly one cycle, after the pipeline register stages (one register stage
// per two Booth steps), in request order. One request per cycle is sustained.
// The receiver cannot hold results off, so it must take each one as it comes.
module booth_signed_multiplier_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [bsm_pkg::OPERAND_WIDTH-1:0] multiplicand,
	input  logic signed [bsm_pkg::OPERAND_WIDTH-1:0] multiplier,
	output logic                                    done,
	output logic signed [bsm_pkg::PRODUCT_WIDTH-1:0] product
);

	localparam int W   = bsm_pkg::OPERAND_WIDTH;
	localparam int NS  = bsm_pkg::NUM_STAGES;
	localparam int SPS = bsm_pkg::STEPS_PER_STAGE;

	bsm_pkg::booth_state_t state_s [NS];
	logic [W:0]            mcand_s [NS];
	logic [NS-1:0]         valid_s;

	bsm_pkg::booth_state_t entry;
	logic [W:0]            mcand_ext;

	assign busy      = 1'b0;
	assign mcand_ext = {multiplicand[W-1], multiplicand};

	always_comb begin
		entry.acc = '0;
		entry.q   = multiplier;
		entry.qx  = 1'b0;
	end

	for (genvar i = 0; i < NS; i++) begin : g_stage
		bsm_pkg::booth_state_t st_in;
		bsm_pkg::booth_state_t st_out;
		logic [W:0]            m_in;
		logic                  v_in;

		if (i == 0) begin : g_first
			assign st_in = entry;
			assign m_in  = mcand_ext;
			assign v_in  = start;
		end else begin : g_next
			assign st_in = state_s[i-1];
			assign m_in  = mcand_s[i-1];
			assign v_in  = valid_s[i-1];
		end

		always_comb begin
			st_out = st_in;
			for (int j = 0; j < SPS; j++) begin
				if (i * SPS + j < W) begin
					st_out = bsm_pkg::booth_step(st_out, m_in);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			state_s[i] <= st_out;
			mcand_s[i] <= m_in;
		end
	end

	assign done    = valid_s[NS-1];
	assign product = {state_s[NS-1].acc[W-1:0], state_s[NS-1].q};

endmodule
